[sv/bfis_pkg.sv]
`default_nettype none
package bfis_pkg;

  localparam int unsigned PIXEL_W   = 16;
  localparam int unsigned FRAC_W    = 8;
  localparam int unsigned ROW_W     = 6;
  localparam int unsigned COL_W     = 6;
  localparam int unsigned SHIFT_W   = 14;
  localparam int unsigned DIM_W     = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 14;
  localparam int unsigned ADDR_W    = ROW_W + COL_W;
  localparam int unsigned DEPTH     = 1 << ADDR_W;
  localparam int unsigned MAX_DIM   = 1 << ROW_W;
  // neighbour coordinates: row plus floored shift plus one, signed
  localparam int unsigned COORD_W   = ROW_W + 2;
  localparam int unsigned WGT_W     = 2 * FRAC_W + 1;
  localparam int unsigned PROD_W    = PIXEL_W + WGT_W + 1;
  localparam int unsigned ACC_W     = PROD_W + 2;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VERT   = 2'd0,
    CFG_HORIZ  = 2'd1,
    CFG_HEIGHT = 2'd2,
    CFG_WIDTH  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic [SHIFT_W-1:0] vert_shift;
    logic [SHIFT_W-1:0] horiz_shift;
    logic [DIM_W-1:0]   plane_height;
    logic [DIM_W-1:0]   plane_width;
  } cfg_t;

  typedef struct packed {
    logic       in_ready;
    logic       mem_wr;
    logic       item_load;
    logic       acc_clr;
    logic       rd_en;
    logic [1:0] rd_idx;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_query;
    logic pipe_busy;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

[sv/bfis_in_if.sv]
`default_nettype none
interface bfis_in_if;
  logic                              valid;
  logic                              ready;
  logic                              op;
  logic [bfis_pkg::ROW_W-1:0]        row;
  logic [bfis_pkg::COL_W-1:0]        col;
  logic signed [bfis_pkg::PIXEL_W-1:0] pixel;

  modport source (output valid, output op, output row, output col, output pixel,
                  input ready);
  modport sink (input valid, input op, input row, input col, input pixel,
                output ready);
endinterface
`default_nettype wire

[sv/bfis_out_if.sv]
`default_nettype none
interface bfis_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [bfis_pkg::PIXEL_W-1:0] shifted_value;

  modport source (output valid, output shifted_value, input ready);
  modport sink (input valid, input shifted_value, output ready);
endinterface
`default_nettype wire

[sv/bfis_ctrl.sv]
`default_nettype none
module bfis_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bfis_pkg::status_t status_i,
  output bfis_pkg::cmd_t         cmd_o
);

  bfis_pkg::state_e state_q, state_d;
  logic [1:0]       idx_q, idx_d;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      bfis_pkg::ST_IDLE: begin
        idx_d = 2'd0;
        if (status_i.in_valid && status_i.in_query) begin
          state_d = bfis_pkg::ST_READ;
        end
      end
      bfis_pkg::ST_READ: begin
        idx_d = idx_q + 2'd1;
        if (idx_q == 2'd3) begin
          state_d = bfis_pkg::ST_DRAIN;
        end
      end
      bfis_pkg::ST_DRAIN: begin
        if (!status_i.pipe_busy && status_i.out_free) begin
          state_d = bfis_pkg::ST_IDLE;
        end
      end
      default: state_d = bfis_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.rd_idx = idx_q;
    unique case (state_q)
      bfis_pkg::ST_IDLE: begin
        cmd_o.in_ready  = 1'b1;
        cmd_o.item_load = status_i.in_valid;
        cmd_o.acc_clr   = status_i.in_valid && status_i.in_query;
        cmd_o.mem_wr    = status_i.in_valid && !status_i.in_query;
      end
      bfis_pkg::ST_READ: begin
        cmd_o.rd_en = 1'b1;
      end
      bfis_pkg::ST_DRAIN: begin
        cmd_o.out_load = !status_i.pipe_busy && status_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfis_pkg::ST_IDLE;
      idx_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule
`default_nettype wire

[sv/bfis_dp.sv]
`default_nettype none
module bfis_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire bfis_pkg::cmd_t                      cmd_i,
  input  wire bfis_pkg::cfg_t                      cfg_i,
  input  wire logic [bfis_pkg::ROW_W-1:0]          in_row_i,
  input  wire logic [bfis_pkg::COL_W-1:0]          in_col_i,
  input  wire logic [bfis_pkg::PIXEL_W-1:0]        in_pixel_i,
  input  wire logic                                out_ready_i,
  output logic                                     out_valid_o,
  output logic [bfis_pkg::PIXEL_W-1:0]             out_value_o,
  output logic                                     pipe_busy_o,
  output logic                                     out_free_o
);

  localparam int unsigned FW = bfis_pkg::FRAC_W;
  localparam int unsigned CW = bfis_pkg::COORD_W;
  localparam int unsigned PW = bfis_pkg::PIXEL_W;
  localparam int unsigned AW = bfis_pkg::ACC_W;
  localparam int unsigned SW = bfis_pkg::SHIFT_W;
  localparam int unsigned RW = AW - 2 * FW;
  localparam int unsigned GW = bfis_pkg::WGT_W;
  localparam int unsigned XW = bfis_pkg::PROD_W;

  logic [PW-1:0] mem [bfis_pkg::DEPTH];

  logic [bfis_pkg::ROW_W-1:0] row_q;
  logic [bfis_pkg::COL_W-1:0] col_q;

  // issue stage
  logic [CW-1:0]               r0, c0, rn, cn;
  logic [bfis_pkg::DIM_W-1:0]  h_eff, w_eff;
  logic                        inb;
  logic [FW-1:0]               frac_a, frac_b;
  logic [FW:0]                 wa, wb;
  logic [GW-1:0]               wprod;
  logic [bfis_pkg::ADDR_W-1:0] rd_addr;

  // pipeline
  logic [PW-1:0]                 rd_data_q;
  logic [GW-1:0]                 w_q;
  logic                          inb_q, v1_q, v2_q;
  logic signed [XW-1:0]          prod_mul, prod_d, prod_q;
  logic signed [AW-1:0]          acc_q, rnd;
  logic signed [RW-1:0]          res;
  logic [PW-1:0]                 sat;
  logic                          out_valid_q;
  logic [PW-1:0]                 out_data_q;

  assign r0 = {2'b00, row_q} + {{(CW-SW+FW){cfg_i.vert_shift[SW-1]}},
                                cfg_i.vert_shift[SW-1:FW]};
  assign c0 = {2'b00, col_q} + {{(CW-SW+FW){cfg_i.horiz_shift[SW-1]}},
                                cfg_i.horiz_shift[SW-1:FW]};
  assign rn = r0 + {{(CW-1){1'b0}}, cmd_i.rd_idx[1]};
  assign cn = c0 + {{(CW-1){1'b0}}, cmd_i.rd_idx[0]};

  assign h_eff = (cfg_i.plane_height > bfis_pkg::DIM_W'(bfis_pkg::MAX_DIM))
               ? bfis_pkg::DIM_W'(bfis_pkg::MAX_DIM) : cfg_i.plane_height;
  assign w_eff = (cfg_i.plane_width > bfis_pkg::DIM_W'(bfis_pkg::MAX_DIM))
               ? bfis_pkg::DIM_W'(bfis_pkg::MAX_DIM) : cfg_i.plane_width;

  // coordinates are never above 95, so the low bits compare directly
  assign inb = !rn[CW-1] && !cn[CW-1]
            && (rn[bfis_pkg::DIM_W-1:0] < h_eff) && (cn[bfis_pkg::DIM_W-1:0] < w_eff);

  assign rd_addr = {rn[bfis_pkg::ROW_W-1:0], cn[bfis_pkg::COL_W-1:0]};

  assign frac_a = cfg_i.vert_shift[FW-1:0];
  assign frac_b = cfg_i.horiz_shift[FW-1:0];
  assign wa = cmd_i.rd_idx[1] ? {1'b0, frac_a} : ((FW+1)'(1 << FW) - {1'b0, frac_a});
  assign wb = cmd_i.rd_idx[0] ? {1'b0, frac_b} : ((FW+1)'(1 << FW) - {1'b0, frac_b});
  assign wprod = {{(GW-FW-1){1'b0}}, wa} * {{(GW-FW-1){1'b0}}, wb};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      mem[{in_row_i, in_col_i}] <= in_pixel_i;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      row_q <= in_row_i;
      col_q <= in_col_i;
    end
    w_q    <= wprod;
    inb_q  <= inb;
    prod_q <= prod_d;
  end

  assign prod_mul = $signed({{(XW-PW){rd_data_q[PW-1]}}, rd_data_q})
                  * $signed({{(XW-GW){1'b0}}, w_q});

  // drop neighbours outside the plane
  assign prod_d = inb_q ? prod_mul : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      acc_q <= '0;
    end else begin
      v1_q <= cmd_i.rd_en;
      v2_q <= v1_q;
      if (cmd_i.acc_clr) begin
        acc_q <= '0;
      end else if (v2_q) begin
        acc_q <= acc_q + AW'(prod_q);
      end
    end
  end

  // round half up, floor shift, saturate
  assign rnd = acc_q + AW'(1 << (2 * FW - 1));
  assign res = rnd[AW-1:2*FW];
  always_comb begin
    if (res > RW'($signed((1 << (PW - 1)) - 1))) begin
      sat = {1'b0, {(PW-1){1'b1}}};
    end else if (res < -RW'($signed(1 << (PW - 1)))) begin
      sat = {1'b1, {(PW-1){1'b0}}};
    end else begin
      sat = res[PW-1:0];
    end
  end

  assign out_free_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_data_q;
  assign pipe_busy_o = v1_q || v2_q;

endmodule
`default_nettype wire

[sv/bilinear_fractional_image_shift_top.sv]
`default_nettype none
// Load beat: written to the plane store in the cycle it is taken, one per cycle
// while no query is in progress. Query beat: four store reads (one per cycle on the
// single store port), then a two-stage multiply-accumulate drain; the result is
// loaded into the output register once the drain is empty and that register is free,
// and only then is the next beat taken. Reset clears control state
// and the shift/size registers (0, 0, 64, 64); the store is not cleared.
module bilinear_fractional_image_shift_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [bfis_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [bfis_pkg::CFG_W-1:0]      cfg_data_i,
  bfis_in_if.sink                              in_if,
  bfis_out_if.source                           out_if
);

  bfis_pkg::cfg_t    cfg_q;
  bfis_pkg::cmd_t    cmd;
  bfis_pkg::status_t status;
  logic              pipe_busy;
  logic              out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vert_shift   <= '0;
      cfg_q.horiz_shift  <= '0;
      cfg_q.plane_height <= bfis_pkg::DIM_W'(bfis_pkg::MAX_DIM);
      cfg_q.plane_width  <= bfis_pkg::DIM_W'(bfis_pkg::MAX_DIM);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bfis_pkg::CFG_VERT:   cfg_q.vert_shift   <= cfg_data_i;
        bfis_pkg::CFG_HORIZ:  cfg_q.horiz_shift  <= cfg_data_i;
        bfis_pkg::CFG_HEIGHT: cfg_q.plane_height <= cfg_data_i[bfis_pkg::DIM_W-1:0];
        bfis_pkg::CFG_WIDTH:  cfg_q.plane_width  <= cfg_data_i[bfis_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign status.in_valid  = in_if.valid;
  assign status.in_query  = (in_if.op == bfis_pkg::OP_QUERY);
  assign status.pipe_busy = pipe_busy;
  assign status.out_free  = out_free;

  assign in_if.ready = cmd.in_ready;

  bfis_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  bfis_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_i       (cfg_q),
    .in_row_i    (in_if.row),
    .in_col_i    (in_if.col),
    .in_pixel_i  (in_if.pixel),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .out_value_o (out_if.shifted_value),
    .pipe_busy_o (pipe_busy),
    .out_free_o  (out_free)
  );

endmodule
`default_nettype wire

[test/bilinear_fractional_image_shift_top_tb.sv]
module bilinear_fractional_image_shift_top_tb;
  import bfis_pkg::*;

  typedef struct {
    op_e                       op;
    logic [ROW_W-1:0]          row;
    logic [COL_W-1:0]          col;
    logic signed [PIXEL_W-1:0] pixel;
  } beat_t;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int TOTAL_ITEMS    = 1350;
  localparam int WINDOW         = 12;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  bfis_in_if  in_bus ();
  bfis_out_if out_bus ();

  bilinear_fractional_image_shift_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_bus),
    .out_if     (out_bus)
  );

  always #5 clk_i = ~clk_i;

  beat_t                     pending_beats[$];
  logic signed [PIXEL_W-1:0] expected_pixels[$];
  logic signed [PIXEL_W-1:0] plane_copy[DEPTH];
  bit                        loaded[DEPTH];
  logic signed [SHIFT_W-1:0] vert_cfg   = '0;
  logic signed [SHIFT_W-1:0] horiz_cfg  = '0;
  logic [DIM_W-1:0]          height_cfg = 7'd64;
  logic [DIM_W-1:0]          width_cfg  = 7'd64;
  idle_mode_e                idle_mode  = IDLE_NONE;
  logic                      in_taken   = 1'b0;
  logic                      out_taken  = 1'b0;
  int                        error_count  = 0;
  int                        stall_cycles = 0;
  int                        items_queued = 0;

  function automatic int eff_dim(logic [DIM_W-1:0] d);
    return (d > MAX_DIM) ? MAX_DIM : int'(d);
  endfunction

  function automatic bit in_plane(int r, int c);
    return r >= 0 && r < eff_dim(height_cfg) && c >= 0 && c < eff_dim(width_cfg);
  endfunction

  // top-left neighbour and fractional weights for an output pixel
  function automatic void neighbour_origin(input logic [ROW_W-1:0] row,
                                           input logic [COL_W-1:0] col,
                                           output int r0, output int c0,
                                           output int a, output int b);
    int v;
    int hz;
    v  = vert_cfg;
    hz = horiz_cfg;
    a  = v & ((1 << FRAC_W) - 1);
    b  = hz & ((1 << FRAC_W) - 1);
    r0 = int'(row) + (v - a) / (1 << FRAC_W);
    c0 = int'(col) + (hz - b) / (1 << FRAC_W);
  endfunction

  function automatic longint neighbour_value(int r, int c);
    if (!in_plane(r, c)) return 0;
    return longint'(plane_copy[r * MAX_DIM + c]);
  endfunction

  function automatic bit query_safe(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
    int r0, c0, a, b;
    neighbour_origin(row, col, r0, c0, a, b);
    for (int dr = 0; dr < 2; dr++) begin
      for (int dc = 0; dc < 2; dc++) begin
        if (in_plane(r0 + dr, c0 + dc) && !loaded[(r0 + dr) * MAX_DIM + c0 + dc]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic logic signed [PIXEL_W-1:0] interpolate_pixel(logic [ROW_W-1:0] row,
                                                                  logic [COL_W-1:0] col);
    int     r0, c0, a, b;
    longint one, acc, res;
    longint lo, hi;
    one = longint'(1) << FRAC_W;
    lo  = -(longint'(1) << (PIXEL_W - 1));
    hi  = (longint'(1) << (PIXEL_W - 1)) - 1;
    neighbour_origin(row, col, r0, c0, a, b);
    acc = (one - a) * ((one - b) * neighbour_value(r0, c0) + b * neighbour_value(r0, c0 + 1))
        + a * ((one - b) * neighbour_value(r0 + 1, c0) + b * neighbour_value(r0 + 1, c0 + 1));
    // round half up, then floor shift
    res = (acc + (longint'(1) << (2 * FRAC_W - 1))) >>> (2 * FRAC_W);
    if (res < lo) res = lo;
    if (res > hi) res = hi;
    return res[PIXEL_W-1:0];
  endfunction

  function automatic bit holds_off(bit is_sender);
    int roll;
    roll = $urandom_range(0, 99);
    if (idle_mode == IDLE_BOTH) return roll < 30;
    if (is_sender) return idle_mode == IDLE_SEND && roll < 61;
    return idle_mode == IDLE_RECV && roll < 61;
  endfunction

  function automatic logic signed [PIXEL_W-1:0] random_pixel();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return PIXEL_W'($urandom);
    endcase
  endfunction

  function automatic logic [SHIFT_W-1:0] random_shift();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 14'h2000;
          1: return 14'h1FFF;
          2: return 14'h1000;
          default: return 14'h3000;
        endcase
      end
      1: return SHIFT_W'($urandom);
      2: return SHIFT_W'((int'($urandom_range(0, 6)) - 3) << FRAC_W);
      default: return SHIFT_W'(int'($urandom_range(0, 1536)) - 768);
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] random_dim();
    case ($urandom_range(0, 11))
      0: return 7'd64;
      1: return DIM_W'($urandom_range(65, 127));
      2: return 7'd0;
      3: return 7'd1;
      4: return 7'd63;
      default: return DIM_W'($urandom_range(2, 10));
    endcase
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_VERT:   vert_cfg   = data[SHIFT_W-1:0];
      CFG_HORIZ:  horiz_cfg  = data[SHIFT_W-1:0];
      CFG_HEIGHT: height_cfg = data[DIM_W-1:0];
      CFG_WIDTH:  width_cfg  = data[DIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [SHIFT_W-1:0] v, logic [SHIFT_W-1:0] h,
                            logic [DIM_W-1:0] ht, logic [DIM_W-1:0] wd);
    write_reg(CFG_VERT, v);
    write_reg(CFG_HORIZ, h);
    write_reg(CFG_HEIGHT, ht);
    write_reg(CFG_WIDTH, wd);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_load(logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                            logic signed [PIXEL_W-1:0] pixel);
    pending_beats.push_back('{OP_LOAD, row, col, pixel});
    loaded[{row, col}] = 1'b1;
    items_queued++;
  endtask

  task automatic queue_query(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
    pending_beats.push_back('{OP_QUERY, row, col, random_pixel()});
    items_queued++;
  endtask

  // let the block drain: nothing left to send, nothing outstanding
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_beats.size() != 0 || in_bus.valid || expected_pixels.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_random_phase();
    int eh, ew, nr, nc, fr, fc, fv, fh, a, b, tr, tc;
    bit found;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    set_config(random_shift(), random_shift(), random_dim(), random_dim());
    eh = eff_dim(height_cfg);
    ew = eff_dim(width_cfg);
    nr = (eh > WINDOW) ? WINDOW : eh;
    nc = (ew > WINDOW) ? WINDOW : ew;
    fr = $urandom_range(0, eh - nr);
    fc = $urandom_range(0, ew - nc);
    // fill a window of the active plane before querying it
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) queue_load(fr + r, fc + c, random_pixel());
    end
    neighbour_origin('0, '0, fv, fh, a, b);
    for (int i = 0; i < 30; i++) begin
      if ($urandom_range(0, 9) < 7) begin
        found = 1'b0;
        for (int t = 0; t < 64 && !found; t++) begin
          row = $urandom_range(0, MAX_DIM - 1);
          col = $urandom_range(0, MAX_DIM - 1);
          // aim half the tries at the filled window
          if (t % 2 == 0) begin
            tr = fr - 1 + int'($urandom_range(0, nr)) - fv;
            tc = fc - 1 + int'($urandom_range(0, nc)) - fh;
            if (tr >= 0 && tr < MAX_DIM) row = tr[ROW_W-1:0];
            if (tc >= 0 && tc < MAX_DIM) col = tc[COL_W-1:0];
          end
          found = query_safe(row, col);
        end
        if (found) queue_query(row, col);
        else queue_load($urandom_range(0, MAX_DIM - 1), $urandom_range(0, MAX_DIM - 1),
                        random_pixel());
      end else begin
        queue_load($urandom_range(0, MAX_DIM - 1), $urandom_range(0, MAX_DIM - 1),
                   random_pixel());
      end
    end
    wait_idle();
  endtask

  always @(negedge clk_i) begin
    beat_t nb;
    if (rst_ni && (!in_bus.valid || in_taken)) begin
      if (pending_beats.size() != 0 && !holds_off(1'b1)) begin
        nb = pending_beats.pop_front();
        in_bus.valid <= 1'b1;
        in_bus.op    <= nb.op;
        in_bus.row   <= nb.row;
        in_bus.col   <= nb.col;
        in_bus.pixel <= nb.pixel;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
    out_bus.ready <= rst_ni && !holds_off(1'b0);
  end

  always @(posedge clk_i) begin
    logic signed [PIXEL_W-1:0] want;
    in_taken  = in_bus.valid && in_bus.ready;
    out_taken = out_bus.valid && out_bus.ready;
    if (out_taken) begin
      if (expected_pixels.size() == 0) begin
        $error("shifted_value: expected none, got %0d", out_bus.shifted_value);
        error_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_bus.shifted_value !== want) begin
          $error("shifted_value: expected %0d, got %0d", want, out_bus.shifted_value);
          error_count++;
        end
      end
    end
    if (in_taken) begin
      if (in_bus.op == OP_LOAD) plane_copy[{in_bus.row, in_bus.col}] = in_bus.pixel;
      else expected_pixels.push_back(interpolate_pixel(in_bus.row, in_bus.col));
    end
    if (in_taken || out_taken || cfg_we_i) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int phase;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    in_bus.valid  = 1'b0;
    in_bus.op     = 1'b0;
    in_bus.row    = '0;
    in_bus.col    = '0;
    in_bus.pixel  = '0;
    out_bus.ready = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // corner blocks with extreme pixels, queried at reset shifts
    queue_load(0, 0, 16'sh7FFF);
    queue_load(0, 1, 16'sh8000);
    queue_load(1, 0, 16'sh8000);
    queue_load(1, 1, 16'sh7FFF);
    queue_load(62, 62, -16'sd1);
    queue_load(62, 63, 16'sd1);
    queue_load(63, 62, 16'sh5555);
    queue_load(63, 63, 16'shAAAA);
    queue_query(0, 0);
    queue_query(62, 62);
    queue_query(63, 63);
    wait_idle();

    // half-pixel shift on both axes, bottom-right edge drops out
    set_config(14'h080, 14'h080, 7'd64, 7'd64);
    queue_query(0, 0);
    queue_query(62, 62);
    queue_query(63, 63);
    wait_idle();

    // empty plane: every neighbour is outside
    set_config(14'h155, 14'h2AA, 7'd0, 7'd0);
    queue_query(63, 0);
    queue_query(0, 63);
    wait_idle();

    // largest shifts, oversized plane registers
    set_config(14'h1FFF, 14'h2000, 7'd127, 7'd127);
    queue_query(33, 40);
    queue_query(63, 63);
    wait_idle();

    phase = 0;
    while (items_queued < TOTAL_ITEMS) begin
      idle_mode = idle_mode_e'(phase % 4);
      run_random_phase();
      phase++;
    end

    wait_idle();
    if (error_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

[sim.f]
sv/bfis_pkg.sv
sv/bfis_in_if.sv
sv/bfis_out_if.sv
sv/bfis_ctrl.sv
sv/bfis_dp.sv
sv/bilinear_fractional_image_shift_top.sv
test/bilinear_fractional_image_shift_top_tb.sv
